// ----- hdl/ssoe_pkg.sv -----
// Shared types, codes and constants for the sorted set operation engine.
`default_nettype none

package ssoe_pkg;

  localparam int VAL_W          = 32;
  localparam int DEF_LIST_DEPTH = 32;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  localparam logic [1:0] OP_MERGE = 2'd0;
  localparam logic [1:0] OP_UNION = 2'd1;
  localparam logic [1:0] OP_INTER = 2'd2;
  localparam logic [1:0] OP_DIFF  = 2'd3;

  localparam logic [1:0] OP_RESET = OP_UNION;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic       ovf;
  } run_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_sts_t;

endpackage

`default_nettype wire

// ----- hdl/sorted_set_operation_engine.sv -----
// Sorted set operation engine: list storage, load control and run sequencing.
//
// Usage:
//   in_* stream: in_tuser selects the action (0 append to first list,
//   1 append to second list, 2 run, 3 ignored); in_tdata is the signed value
//   appended on a load. Loads into a full list are dropped and flagged as
//   overflow on the next run's output.
//   cfg_* port: writes the 2-bit operation (0 merge, 1 union, 2 intersection,
//   3 difference); always ready; user writes it only when idle (not enforced).
//   out_* stream: one beat per result value, ascending, out_tlast on the
//   final beat of a run; an empty result gives a single marker beat with
//   result_valid low. out_tuser carries result_valid and overflow.
//   A run steps through the two-pointer walk (at most first count + second
//   count steps), then detects the end, flushes the last beat and clears the
//   counts; each step is one pass through the shared compare unit on the
//   two registered RAM reads. in_tready stays low for the whole run.
//   When the receiver stalls, the walk holds with the output beat held.
//   After a run both lists and the overflow flag are emptied.
//   Reset empties both lists, clears overflow and sets the operation to union.
`default_nettype none

module sorted_set_operation_engine
  import ssoe_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] element_value
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] result_value
  output logic      [1:0]  out_tuser,  // [0] result_valid, [1] overflow
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data    // [1:0] set_operation
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [1:0]       op_r, op_nxt;
  logic [CW-1:0]    cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic             drop_r, drop_nxt;
  logic             in_acc, wr_a, wr_b;
  logic [AW-1:0]    a_addr, b_addr;
  logic [VAL_W-1:0] a_rd, b_rd;
  run_ctl_t         ctl;
  walk_sts_t        sts;

  assign in_tready = !sts.busy && !sts.done;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    drop_nxt  = drop_r;
    op_nxt    = (cfg_valid && cfg_ready) ? cfg_data : op_r;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    ctl.start = 1'b0;
    ctl.op    = op_r;
    ctl.ovf   = drop_r;
    if (sts.done) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      drop_nxt  = 1'b0;
    end else if (in_acc) begin
      unique case (in_tuser)
        FUNC_LOAD_A: begin
          if (cnt_a_r < CW'(LIST_DEPTH)) begin
            wr_a      = 1'b1;
            cnt_a_nxt = cnt_a_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
        FUNC_LOAD_B: begin
          if (cnt_b_r < CW'(LIST_DEPTH)) begin
            wr_b      = 1'b1;
            cnt_b_nxt = cnt_b_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
        FUNC_RUN: ctl.start = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_RESET;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      op_r    <= op_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      drop_r  <= drop_nxt;
    end
  end

  ssoe_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH), .ADDR_W(AW)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (a_addr),
    .rd_data (a_rd)
  );

  ssoe_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH), .ADDR_W(AW)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (b_addr),
    .rd_data (b_rd)
  );

  ssoe_walk #(.LIST_DEPTH(LIST_DEPTH), .CW(CW), .AW(AW)) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .na         (cnt_a_r),
    .nb         (cnt_b_r),
    .a_rd       (a_rd),
    .b_rd       (b_rd),
    .a_addr     (a_addr),
    .b_addr     (b_addr),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_rvalid (out_tuser[0]),
    .out_ovf    (out_tuser[1]),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/ssoe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssoe_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/ssoe_cmp.sv -----
// Shared signed compare unit used by every step of the merge walk.
`default_nettype none

module ssoe_cmp
  import ssoe_pkg::*;
(
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  output cmp_t                  res
);

  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

// ----- hdl/ssoe_walk.sv -----
// Two-pointer merge sequencer with one-deep hold buffer and output register.
`default_nettype none

module ssoe_walk
  import ssoe_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int CW         = $clog2(LIST_DEPTH + 1),
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire run_ctl_t         ctl,
  input  wire logic [CW-1:0]    na,
  input  wire logic [CW-1:0]    nb,
  input  wire logic [VAL_W-1:0] a_rd,
  input  wire logic [VAL_W-1:0] b_rd,
  output logic      [AW-1:0]    a_addr,
  output logic      [AW-1:0]    b_addr,
  output walk_sts_t             sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [VAL_W-1:0] out_value,
  output logic                  out_rvalid,
  output logic                  out_ovf,
  output logic                  out_last
);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [VAL_W-1:0] hold_r, hold_nxt;
  logic             ovf_r, ovf_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             ov_r, ov_nxt;
  logic [VAL_W-1:0] ovalue_r, ovalue_nxt;
  logic             orv_r, orv_nxt, oovf_r, oovf_nxt, olast_r, olast_nxt;
  logic             done_r, done_nxt;

  cmp_t             cmp;
  logic             can_push, a_more, b_more;
  logic             emit, adv_i, adv_j, fin;
  logic [VAL_W-1:0] ev;

  ssoe_cmp u_cmp (
    .a   (a_rd),
    .b   (b_rd),
    .res (cmp)
  );

  assign can_push = !ov_r || out_ready;
  assign a_more   = (i_r < na);
  assign b_more   = (j_r < nb);

  always_comb begin
    emit  = 1'b0;
    adv_i = 1'b0;
    adv_j = 1'b0;
    fin   = 1'b0;
    ev    = a_rd;
    if (a_more && b_more) begin
      if (cmp.lt) begin
        emit  = (op_r != OP_INTER);
        adv_i = 1'b1;
      end else if (op_r == OP_MERGE) begin
        emit  = 1'b1;
        ev    = b_rd;
        adv_j = 1'b1;
      end else if (!cmp.eq) begin
        emit  = (op_r == OP_UNION);
        ev    = b_rd;
        adv_j = 1'b1;
      end else begin
        emit  = (op_r == OP_UNION) || (op_r == OP_INTER);
        adv_i = 1'b1;
        adv_j = 1'b1;
      end
    end else if (a_more && op_r != OP_INTER) begin
      emit  = 1'b1;
      adv_i = 1'b1;
    end else if (b_more && (op_r == OP_MERGE || op_r == OP_UNION)) begin
      emit  = 1'b1;
      ev    = b_rd;
      adv_j = 1'b1;
    end else begin
      fin = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    ovf_nxt    = ovf_r;
    op_nxt     = op_r;
    ov_nxt     = ov_r && !out_ready;
    ovalue_nxt = ovalue_r;
    orv_nxt    = orv_r;
    oovf_nxt   = oovf_r;
    olast_nxt  = olast_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          op_nxt    = ctl.op;
          ovf_nxt   = ctl.ovf;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (can_push) begin
          if (fin) begin
            state_nxt = ST_FLUSH;
          end else begin
            if (adv_i) i_nxt = i_r + CW'(1);
            if (adv_j) j_nxt = j_r + CW'(1);
            if (emit) begin
              if (hold_v_r) begin
                ov_nxt     = 1'b1;
                ovalue_nxt = hold_r;
                orv_nxt    = 1'b1;
                oovf_nxt   = ovf_r;
                olast_nxt  = 1'b0;
              end
              hold_v_nxt = 1'b1;
              hold_nxt   = ev;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          ov_nxt     = 1'b1;
          ovalue_nxt = hold_v_r ? hold_r : '0;
          orv_nxt    = hold_v_r;
          oovf_nxt   = ovf_r;
          olast_nxt  = 1'b1;
          hold_v_nxt = 1'b0;
          i_nxt      = '0;
          j_nxt      = '0;
          done_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
      done_r   <= 1'b0;
      op_r     <= OP_RESET;
      ovf_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
      done_r   <= done_nxt;
      op_r     <= op_nxt;
      ovf_r    <= ovf_nxt;
    end
    hold_r   <= hold_nxt;
    ovalue_r <= ovalue_nxt;
    orv_r    <= orv_nxt;
    oovf_r   <= oovf_nxt;
    olast_r  <= olast_nxt;
  end

  assign a_addr     = i_nxt[AW-1:0];
  assign b_addr     = j_nxt[AW-1:0];
  assign sts.busy   = (state_r != ST_IDLE);
  assign sts.done   = done_r;
  assign out_valid  = ov_r;
  assign out_value  = ovalue_r;
  assign out_rvalid = orv_r;
  assign out_ovf    = oovf_r;
  assign out_last   = olast_r;

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> (i_r <= na) && (j_r <= nb))
    else $error("walk pointer beyond list count");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !hold_v_r && i_r == '0 && j_r == '0)
    else $error("walk state not cleared in idle");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !orv_r |-> olast_r && ovalue_r == '0)
    else $error("empty marker malformed");

  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && can_push |=> ov_r && olast_r && done_r)
    else $error("flush did not deliver final beat");

endmodule

`default_nettype wire
